>>> design/sobel_edge_threshold_top_assert.svh
// Assertion macros shared by the sobel edge threshold RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH

// cond must never be true outside reset
`define SOBEL_ET_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// ante in one cycle implies cons in the next
`define SOBEL_ET_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sobel_et_pkg.sv
// Shared types and constants for the sobel edge threshold block.
// No dependencies.
package sobel_et_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int MIN_SIZE     = 3;

   localparam int PIX_W  = 8;
   localparam int SIZE_W = 11;
   localparam int THR_W  = 8;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
   // compare width wide enough for sizes and counts alike
   localparam int CMP_W  = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(110);
   localparam logic [PIX_W-1:0]  EDGE_ON         = PIX_W'(255);
   localparam logic [PIX_W-1:0]  EDGE_OFF        = PIX_W'(0);

   // CSR register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // one column of the window plus what the back end needs to finish a pixel
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
      logic             active;     // not in the two-row / two-column border
      logic             frame_end;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic              nonempty;
      logic [QCNT_W-1:0] level;
   } fifo_stat_type;

endpackage

>>> design/sobel_et_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sobel_et_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sobel_et_front.sv
// Front end: accepts pixels, tracks raster position, reads and updates line stores.
// Depends on sobel_et_pkg and sobel_et_ram.
module sobel_et_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sobel_et_pkg::PIX_W-1:0]       req_pixel,
   input  logic [sobel_et_pkg::SIZE_W-1:0]      image_width,
   input  logic [sobel_et_pkg::SIZE_W-1:0]      image_height,
   input  sobel_et_pkg::fifo_stat_type          fifo_stat,
   output sobel_et_pkg::push_type               push
);

   localparam int CW = sobel_et_pkg::CMP_W;

   logic                                  accept;
   logic [CW-1:0]                         w_raw, h_raw, w_eff, h_eff;
   logic [CW-1:0]                         col_ext, row_ext;
   logic                                  last_col, last_row;
   logic [sobel_et_pkg::QCNT_W:0]         reserved;

   logic [sobel_et_pkg::COL_W-1:0]        col_ff, col_in;
   logic [sobel_et_pkg::ROW_W-1:0]        row_ff, row_in;

   logic                                  s1_valid_ff, s1_valid_in;
   logic [sobel_et_pkg::COL_W-1:0]        s1_col_ff;
   logic [sobel_et_pkg::PIX_W-1:0]        s1_bot_ff;
   logic                                  s1_active_ff;
   logic                                  s1_fend_ff;

   logic [sobel_et_pkg::PIX_W-1:0]        older_rd, newer_rd;

   // room in the queue for this beat plus the one already reading the RAMs
   assign reserved  = {1'b0, fifo_stat.level} + (sobel_et_pkg::QCNT_W + 1)'(s1_valid_ff);
   assign req_stall = reserved >= (sobel_et_pkg::QCNT_W + 1)'(sobel_et_pkg::QDEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      w_raw = CW'(image_width);
      h_raw = CW'(image_height);
      if (w_raw < CW'(sobel_et_pkg::MIN_SIZE)) begin
         w_eff = CW'(sobel_et_pkg::MIN_SIZE);
      end else if (w_raw > CW'(sobel_et_pkg::MAX_WIDTH)) begin
         w_eff = CW'(sobel_et_pkg::MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw < CW'(sobel_et_pkg::MIN_SIZE)) begin
         h_eff = CW'(sobel_et_pkg::MIN_SIZE);
      end else if (h_raw > CW'(sobel_et_pkg::HEIGHT_LIMIT)) begin
         h_eff = CW'(sobel_et_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = h_raw;
      end
   end

   assign col_ext  = CW'(col_ff);
   assign row_ext  = CW'(row_ff);
   assign last_col = (col_ext + CW'(1)) >= w_eff;
   assign last_row = (row_ext + CW'(1)) >= h_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + sobel_et_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + sobel_et_pkg::COL_W'(1);
         end
      end
   end

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= col_ff;
         s1_bot_ff    <= req_pixel;
         s1_active_ff <= (row_ff >= sobel_et_pkg::ROW_W'(2)) &&
                         (col_ff >= sobel_et_pkg::COL_W'(2));
         s1_fend_ff   <= (col_ext == w_eff - CW'(1)) && (row_ext == h_eff - CW'(1));
      end
   end

   // older line: row r-2, newer line: row r-1; rows shift down on write-back
   sobel_et_ram #(
      .WIDTH (sobel_et_pkg::PIX_W),
      .DEPTH (sobel_et_pkg::MAX_WIDTH)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (newer_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   sobel_et_ram #(
      .WIDTH (sobel_et_pkg::PIX_W),
      .DEPTH (sobel_et_pkg::MAX_WIDTH)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_bot_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (newer_rd)
   );

   always_comb begin
      push.valid          = s1_valid_ff;
      push.item.top       = older_rd;
      push.item.mid       = newer_rd;
      push.item.bot       = s1_bot_ff;
      push.item.active    = s1_active_ff;
      push.item.frame_end = s1_fend_ff;
   end

endmodule

>>> design/sobel_et_fifo.sv
// Short queue of window columns between the front and back ends.
// Depends on sobel_et_pkg and sobel_edge_threshold_top_assert.svh.
`include "sobel_edge_threshold_top_assert.svh"

module sobel_et_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  sobel_et_pkg::push_type      push,
   input  logic                        pop,
   output sobel_et_pkg::item_type      head,
   output sobel_et_pkg::fifo_stat_type fifo_stat
);

   sobel_et_pkg::item_type              mem_ff [sobel_et_pkg::QDEPTH];
   logic [sobel_et_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sobel_et_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sobel_et_pkg::QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + sobel_et_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sobel_et_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + sobel_et_pkg::QCNT_W'(1);
      end else if (!push.valid && pop) begin
         count_in = count_ff - sobel_et_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head               = mem_ff[rd_ptr_ff];
   assign fifo_stat.nonempty = count_ff != '0;
   assign fifo_stat.level    = count_ff;

   `SOBEL_ET_NEVER(ast_no_overflow, clock, reset,
      push.valid && !pop && count_ff == sobel_et_pkg::QCNT_W'(sobel_et_pkg::QDEPTH),
      "queue written while full")
   `SOBEL_ET_NEVER(ast_no_underflow, clock, reset, pop && count_ff == '0,
      "queue read while empty")
   `SOBEL_ET_NEXT(ast_fill_step, clock, reset, push.valid && !pop,
      count_ff == $past(count_ff) + sobel_et_pkg::QCNT_W'(1),
      "queue level did not follow a lone write")

endmodule

>>> design/sobel_et_back.sv
// Back end: 3x3 window, Sobel gradients, L1 magnitude, threshold and output register.
// Depends on sobel_et_pkg.
module sobel_et_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sobel_et_pkg::item_type            head,
   input  sobel_et_pkg::fifo_stat_type       fifo_stat,
   input  logic [sobel_et_pkg::THR_W-1:0]    edge_threshold,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sobel_et_pkg::PIX_W-1:0]    rsp_edge_pixel,
   output logic                              rsp_frame_end
);

   localparam int PW = sobel_et_pkg::PIX_W;
   localparam int SW = PW + 2;    // weighted column sum, up to 4*255
   localparam int DW = SW + 1;    // signed difference
   localparam int MW = SW + 1;    // |gx| + |gy|

   // win_ff[0..2]: column c-2 top/mid/bot, win_ff[3..5]: column c-1
   logic [PW-1:0]        win_ff [6];
   logic [PW-1:0]        win_in [6];

   logic [SW-1:0]        pos_x, neg_x, pos_y, neg_y;
   logic signed [DW-1:0] gx, gy;
   logic [SW-1:0]        abs_x, abs_y;
   logic [MW-1:0]        mag;
   logic [PW-1:0]        mag_clamped;
   logic                 is_edge;

   logic                 out_valid_ff, out_valid_in;
   logic [PW-1:0]        edge_ff;
   logic                 fend_ff;

   assign pop = fifo_stat.nonempty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      pos_x = SW'(head.top) + {1'b0, head.mid, 1'b0} + SW'(head.bot);
      neg_x = SW'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + SW'(win_ff[2]);
      pos_y = SW'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + SW'(head.top);
      neg_y = SW'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + SW'(head.bot);
      gx    = signed'({1'b0, pos_x}) - signed'({1'b0, neg_x});
      gy    = signed'({1'b0, pos_y}) - signed'({1'b0, neg_y});
      abs_x = gx[DW-1] ? SW'(-gx) : SW'(gx);
      abs_y = gy[DW-1] ? SW'(-gy) : SW'(gy);
      mag   = MW'(abs_x) + MW'(abs_y);
      mag_clamped = (mag > MW'(sobel_et_pkg::EDGE_ON)) ? sobel_et_pkg::EDGE_ON : mag[PW-1:0];
      is_edge = head.active && (mag_clamped >= edge_threshold);
   end

   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = head.top;
      win_in[4] = head.mid;
      win_in[5] = head.bot;
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            for (int i = 0; i < 6; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         edge_ff <= is_edge ? sobel_et_pkg::EDGE_ON : sobel_et_pkg::EDGE_OFF;
         fend_ff <= head.frame_end;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_edge_pixel = edge_ff;
   assign rsp_frame_end  = fend_ff;

endmodule

>>> design/sobel_edge_threshold_top.sv
// Top level of the Sobel 3x3 edge detector with L1 magnitude threshold.
// Depends on sobel_et_pkg, sobel_et_front, sobel_et_fifo, sobel_et_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_pixel[7:0]
//   rsp_      out        rsp_valid / rsp_stall  rsp_edge_pixel[7:0], rsp_frame_end
//   csr_      in         csr_valid / csr_ready  csr_index[1:0], csr_wdata[10:0]
//
// One pixel per clock sustained while req_stall stays low; each accepted beat gives
// one result through the line-store read, queue, gradient and output register.
// The line-store RAMs have one read and one write port; each pixel reads its
// column and writes it back in the following cycle, so every cycle can take a pixel.
// Synchronous active-high reset clears position counters, window, queue and
// output valid; line-store contents stay undefined until written.
// req_stall rises only when the 4-entry queue is about to fill, i.e. when the
// output register is held by rsp_stall; csr_ready is always high.
module sobel_edge_threshold_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sobel_et_pkg::PIX_W-1:0]        req_pixel,
   // edge output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sobel_et_pkg::PIX_W-1:0]        rsp_edge_pixel,
   output logic                                  rsp_frame_end,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sobel_et_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sobel_et_pkg::SIZE_W-1:0]       csr_wdata
);

   logic [sobel_et_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [sobel_et_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [sobel_et_pkg::THR_W-1:0]  thresh_ff, thresh_in;

   sobel_et_pkg::push_type          push;
   sobel_et_pkg::item_type          head;
   sobel_et_pkg::fifo_stat_type     fifo_stat;
   logic                            pop;

   assign csr_ready = 1'b1;

   // register file; an index past the list is dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sobel_et_pkg::CSR_IMAGE_WIDTH:    width_in  = csr_wdata;
            sobel_et_pkg::CSR_IMAGE_HEIGHT:   height_in = csr_wdata;
            sobel_et_pkg::CSR_EDGE_THRESHOLD: thresh_in = csr_wdata[sobel_et_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sobel_et_pkg::WIDTH_RESET;
         height_ff <= sobel_et_pkg::HEIGHT_RESET;
         thresh_ff <= sobel_et_pkg::THRESHOLD_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thresh_ff <= thresh_in;
      end
   end

   // front: raster position, line stores, border and frame-end flags
   sobel_et_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .image_width  (width_ff),
      .image_height (height_ff),
      .fifo_stat    (fifo_stat),
      .push         (push)
   );

   // decoupling queue; front reserves a slot before reading the RAMs
   sobel_et_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .fifo_stat (fifo_stat)
   );

   // back: window shift, gradients, threshold, output register
   sobel_et_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .fifo_stat      (fifo_stat),
      .edge_threshold (thresh_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_edge_pixel (rsp_edge_pixel),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule
